// ===== design/lrt_pkg.sv =====
// Shared types, codes and constants of the lease reservation table.
// Used by lrt_ctrl, lrt_datapath and lease_reservation_table; no dependencies.
package lrt_pkg;

  localparam int NUM_ENTRIES_DEF = 32;
  localparam int NUM_USERS_DEF   = 16;
  // At most this many entries are ever addressed by reserve, sweep or free-by-user.
  localparam int MAX_ACTIVE      = 32;

  localparam int KIND_W  = 2;
  localparam int USER_W  = 4;
  localparam int RIDX_W  = 8;
  localparam int LIFE_W  = 32;
  localparam int TIME_W  = 48;
  localparam int RESP_W  = 2;
  localparam int RELI_W  = 5;
  localparam int RIU_W   = 6;
  localparam int MASK_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_RESERVE   = 2'd0,
    KIND_SWEEP     = 2'd1,
    KIND_FREE_USER = 2'd2,
    KIND_FREE_ALL  = 2'd3
  } kind_t;

  typedef enum logic [RESP_W-1:0] {
    RESP_OK        = 2'd0,
    RESP_INVALID   = 2'd1,
    RESP_NO_ACCESS = 2'd2,
    RESP_BUSY      = 2'd3
  } resp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESOURCES_IN_USE = 1'd0,
    CFG_USER_ACCESS_MASK = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [USER_W-1:0] user_id;
    logic [RIDX_W-1:0] resource_index;
    logic [LIFE_W-1:0] lifetime_ms;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [RESP_W-1:0] response;
    logic              released_valid;
    logic [USER_W-1:0] released_user;
    logic [RELI_W-1:0] released_index;
    logic              last;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;      // take the request word, rewind scan pointer
    logic clear_all;    // free every entry
    logic use_req_addr; // address the table with the requested index
    logic rsv_commit;   // decide reserve, update entry, load answer
    logic scan_adv;     // act on current scan entry, advance pointer
    logic emit_final;   // load the closing word of a scan or free-all
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic              scan_end;
    logic              rel;
    logic              pend_valid;
    logic              out_free;
  } sts_t;

endpackage

// ===== design/lease_reservation_table.sv =====
// Top level of the lease reservation table: joins lrt_ctrl and lrt_datapath.
// Depends on lrt_pkg, lrt_ctrl and lrt_datapath.
//
// Usage. Request words (kind, user, index, lifetime, time stamp) enter on the
// req channel and result words leave on the rsp channel, both valid/ready.
// Configuration writes (active resource count, user access mask) go through
// cfg_we/cfg_index/cfg_data and take effect at the next edge; write them only
// while the table is idle.
//
// Timing. One request word is worked at a time; req_ready is high only when
// the controller is idle. A reserve word loads its single answer from the
// reserve state once the output register is free. Sweep and free-by-user
// words step the scan pointer over the active entries, one entry per cycle
// through the shared expiry adder while the scan does not hold for a full
// output, and then load the closing word. Free-all clears every busy bit at
// acceptance and answers from the final state once the output register is free.
//
// Each release is held one step so the final word can carry last; a release
// is pushed to the output register only when the next one is found or the
// scan ends. When the receiver stalls, the output register holds its word and
// the scan waits at the entry that would overwrite it. The next request word
// is accepted while a finished result still waits in the output register.
// Reset empties the table and the output, sets the active count to 32 and
// closes access to every user. Entries beyond 32 are never addressed.
module lease_reservation_table #(
  parameter int NUM_ENTRIES = lrt_pkg::NUM_ENTRIES_DEF,
  parameter int NUM_USERS   = lrt_pkg::NUM_USERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  lrt_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output lrt_pkg::rsp_t                  rsp
);

  lrt_pkg::cmd_t cmd;
  lrt_pkg::sts_t sts;

  // Sequencer: decode the request kind, hold on a full output.
  lrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_kind  (req.kind),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table storage, expiry compare and result register.
  lrt_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .NUM_USERS   (NUM_USERS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== design/lrt_datapath.sv =====
// Datapath of the lease reservation table: config registers, entry storage,
// expiry compare, scan pointer, pending release and output register. Uses lrt_pkg.
module lrt_datapath #(
  parameter int NUM_ENTRIES = lrt_pkg::NUM_ENTRIES_DEF,
  parameter int NUM_USERS   = lrt_pkg::NUM_USERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  lrt_pkg::req_t                  req,
  input  lrt_pkg::cmd_t                  cmd,
  output lrt_pkg::sts_t                  sts,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output lrt_pkg::rsp_t                  rsp
);

  localparam int DEPTH = (NUM_ENTRIES < lrt_pkg::MAX_ACTIVE) ? NUM_ENTRIES
                                                            : lrt_pkg::MAX_ACTIVE;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [lrt_pkg::RIU_W-1:0]  res_in_use;
  logic [lrt_pkg::MASK_W-1:0] access_mask;

  lrt_pkg::req_t cur;

  logic [CNT_W-1:0]            ptr;
  logic                        pend_valid;
  logic [lrt_pkg::USER_W-1:0]  pend_owner;
  logic [lrt_pkg::RELI_W-1:0]  pend_index;

  logic [DEPTH-1:0]            busy;
  logic [lrt_pkg::USER_W-1:0]  owner_mem [DEPTH];
  logic [lrt_pkg::TIME_W-1:0]  start_mem [DEPTH];
  logic [lrt_pkg::LIFE_W-1:0]  life_mem  [DEPTH];

  logic [CNT_W-1:0]            n_act;
  logic [IDX_W-1:0]            ptr_idx;
  logic [IDX_W-1:0]            addr;
  logic [IDX_W-1:0]            rd_addr;
  logic                        e_busy;
  logic [lrt_pkg::USER_W-1:0]  e_owner;
  logic [lrt_pkg::TIME_W-1:0]  e_start;
  logic [lrt_pkg::LIFE_W-1:0]  e_life;
  logic [lrt_pkg::TIME_W:0]    e_end;
  logic                        expired;
  logic                        scan_end;
  logic                        rel;
  logic                        owner_match;

  logic                        in_range;
  logic                        has_access;
  logic                        renew;
  logic                        take;
  lrt_pkg::resp_t              rsv_resp;

  logic                        out_free;
  logic                        emit_pend;
  logic                        load_out;
  lrt_pkg::rsp_t               out_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_in_use  <= lrt_pkg::RIU_W'(32);
      access_mask <= '0;
    end else if (cfg_we) begin
      unique case (lrt_pkg::cfg_reg_t'(cfg_index))
        lrt_pkg::CFG_RESOURCES_IN_USE: res_in_use  <= cfg_data[lrt_pkg::RIU_W-1:0];
        lrt_pkg::CFG_USER_ACCESS_MASK: access_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n_act = (res_in_use > lrt_pkg::RIU_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                         : CNT_W'(res_in_use);

  // Entry access, one address at a time.
  assign ptr_idx = ptr[IDX_W-1:0];
  assign addr    = cmd.use_req_addr ? cur.resource_index[IDX_W-1:0] : ptr_idx;
  assign e_busy  = busy[addr];

  // Payload read is registered: fetch the requested entry at acceptance, and
  // fetch one entry ahead whenever the scan pointer advances.
  always_comb begin
    priority if (cmd.capture) begin
      rd_addr = (req.kind == lrt_pkg::KIND_RESERVE) ? req.resource_index[IDX_W-1:0]
                                                    : '0;
    end else if (cmd.use_req_addr) begin
      rd_addr = cur.resource_index[IDX_W-1:0];
    end else if (cmd.scan_adv) begin
      rd_addr = ptr_idx + IDX_W'(1);
    end else begin
      rd_addr = ptr_idx;
    end
  end

  always_ff @(posedge clk) begin
    e_owner <= owner_mem[rd_addr];
    e_start <= start_mem[rd_addr];
    e_life  <= life_mem[rd_addr];
  end

  // Exact end time, one bit wider than the time stamp.
  assign e_end       = {1'b0, e_start} + (lrt_pkg::TIME_W + 1)'(e_life);
  assign expired     = e_end < {1'b0, cur.now_ms};
  assign owner_match = e_owner == cur.user_id;

  assign scan_end = ptr >= n_act;
  assign rel = !scan_end && e_busy &&
               ((cur.kind == lrt_pkg::KIND_SWEEP) ? expired : owner_match);

  // Reserve decision.
  assign in_range   = cur.resource_index < lrt_pkg::RIDX_W'(n_act);
  assign has_access = (32'(cur.user_id) < NUM_USERS) && access_mask[cur.user_id];
  assign renew      = e_busy && owner_match;
  assign take       = !e_busy || (!owner_match && expired);

  always_comb begin
    priority if (!in_range)   rsv_resp = lrt_pkg::RESP_INVALID;
    else if (!has_access)     rsv_resp = lrt_pkg::RESP_NO_ACCESS;
    else if (renew || take)   rsv_resp = lrt_pkg::RESP_OK;
    else                      rsv_resp = lrt_pkg::RESP_BUSY;
  end

  // Request word and scan state.
  always_ff @(posedge clk) begin
    if (cmd.capture) cur <= req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.capture) begin
      ptr        <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.scan_adv) begin
      ptr <= ptr + CNT_W'(1);
      if (rel) pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_adv && rel) begin
      pend_owner <= e_owner;
      pend_index <= lrt_pkg::RELI_W'(ptr_idx);
    end
  end

  // Busy bits reset at once; payload is only read behind a busy bit.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      busy <= '0;
    end else if (cmd.rsv_commit && in_range && has_access && take) begin
      busy[addr] <= 1'b1;
    end else if (cmd.scan_adv && rel) begin
      busy[addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsv_commit && in_range && has_access && (renew || take)) begin
      start_mem[addr] <= cur.now_ms;
      if (take) begin
        owner_mem[addr] <= cur.user_id;
        life_mem[addr]  <= cur.lifetime_ms;
      end
    end
  end

  // Output register.
  assign out_free  = !rsp_valid || rsp_ready;
  assign emit_pend = cmd.scan_adv && rel && pend_valid;
  assign load_out  = cmd.rsv_commit || cmd.emit_final || emit_pend;

  always_comb begin
    out_next = '0;
    priority if (cmd.rsv_commit) begin
      out_next.response = rsv_resp;
      out_next.last     = 1'b1;
    end else if (emit_pend) begin
      out_next.released_valid = 1'b1;
      out_next.released_user  = pend_owner;
      out_next.released_index = pend_index;
    end else begin
      out_next.released_valid = pend_valid;
      out_next.released_user  = pend_valid ? pend_owner : '0;
      out_next.released_index = pend_valid ? pend_index : '0;
      out_next.last           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) rsp <= out_next;
  end

  assign sts.scan_end   = scan_end;
  assign sts.rel        = rel;
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = out_free;

endmodule

// ===== design/lrt_ctrl.sv =====
// Controller of the lease reservation table: sequences reserve, scan and
// free-all items over lrt_datapath. Uses lrt_pkg.
module lrt_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [lrt_pkg::KIND_W-1:0]  req_kind,
  input  lrt_pkg::sts_t               sts,
  output lrt_pkg::cmd_t               cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RSV  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_ready = state == ST_IDLE;
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          unique case (lrt_pkg::kind_t'(req_kind))
            lrt_pkg::KIND_RESERVE: state_next = ST_RSV;
            lrt_pkg::KIND_FREE_ALL: begin
              cmd.clear_all = 1'b1;
              state_next    = ST_FIN;
            end
            default: state_next = ST_SCAN;
          endcase
        end
      end
      ST_RSV: begin
        cmd.use_req_addr = 1'b1;
        if (sts.out_free) begin
          cmd.rsv_commit = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Hold when a release must push out the pending one and the output is full.
        priority if (sts.scan_end) begin
          state_next = ST_FIN;
        end else if (!(sts.rel && sts.pend_valid && !sts.out_free)) begin
          cmd.scan_adv = 1'b1;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule
